// ===== rtl/core/efmdec_pkg.sv =====
// shared types, constants and the eight-to-fourteen code table
package efmdec_pkg;

   localparam int NOMINAL_FRAME_BITS = 588;
   localparam int DATA_SYMBOLS = 32;
   localparam int SUBCODE_START = 27;
   localparam int DATA_START = 44;
   localparam int SYMBOL_PITCH = 17;
   localparam int SYMBOL_BITS = 14;
   localparam int WINDOW_BITS = 24;
   localparam int MAX_OFFSET = WINDOW_BITS - SYMBOL_BITS + 1;
   localparam int COUNT_BITS = 10;
   localparam int POS_BITS = 11;
   localparam int T_MIN = 3;
   localparam int T_MAX = 11;

   localparam logic [13:0] SYNC0_CODE = 14'h0801;
   localparam logic [13:0] SYNC1_CODE = 14'h0012;

   typedef enum logic [1:0] {
      KIND_SUBCODE = 2'd0,
      KIND_SYNC0   = 2'd1,
      KIND_SYNC1   = 2'd2,
      KIND_DATA    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      LEN_GOOD  = 2'd0,
      LEN_SHORT = 2'd1,
      LEN_LONG  = 2'd2
   } len_class_type;

   typedef struct packed {
      logic       sync0;
      logic       sync1;
      logic       hit;
      logic [7:0] value;
   } dec_type;

   localparam logic [13:0] EFM_CODE [256] = '{
      14'b01001000100000, 14'b10000100000000, 14'b10010000100000, 14'b10001000100000,
      14'b01000100000000, 14'b00000100010000, 14'b00010000100000, 14'b00100100000000,
      14'b01001001000000, 14'b10000001000000, 14'b10010001000000, 14'b10001001000000,
      14'b01000001000000, 14'b00000001000000, 14'b00010001000000, 14'b00100001000000,
      14'b10000000100000, 14'b10000010000000, 14'b10010010000000, 14'b00100000100000,
      14'b01000010000000, 14'b00000010000000, 14'b00010010000000, 14'b00100010000000,
      14'b01001000010000, 14'b10000000010000, 14'b10010000010000, 14'b10001000010000,
      14'b01000000010000, 14'b00001000010000, 14'b00010000010000, 14'b00100000010000,
      14'b00000000100000, 14'b10000100001000, 14'b00001000100000, 14'b00100100100000,
      14'b01000100001000, 14'b00000100001000, 14'b01000000100000, 14'b00100100001000,
      14'b01001001001000, 14'b10000001001000, 14'b10010001001000, 14'b10001001001000,
      14'b01000001001000, 14'b00000001001000, 14'b00010001001000, 14'b00100001001000,
      14'b00000100000000, 14'b10000010001000, 14'b10010010001000, 14'b10000100010000,
      14'b01000010001000, 14'b00000010001000, 14'b00010010001000, 14'b00100010001000,
      14'b01001000001000, 14'b10000000001000, 14'b10010000001000, 14'b10001000001000,
      14'b01000000001000, 14'b00001000001000, 14'b00010000001000, 14'b00100000001000,
      14'b01001000100100, 14'b10000100100100, 14'b10010000100100, 14'b10001000100100,
      14'b01000100100100, 14'b00000000100100, 14'b00010000100100, 14'b00100100100100,
      14'b01001001000100, 14'b10000001000100, 14'b10010001000100, 14'b10001001000100,
      14'b01000001000100, 14'b00000001000100, 14'b00010001000100, 14'b00100001000100,
      14'b10000000100100, 14'b10000010000100, 14'b10010010000100, 14'b00100000100100,
      14'b01000010000100, 14'b00000010000100, 14'b00010010000100, 14'b00100010000100,
      14'b01001000000100, 14'b10000000000100, 14'b10010000000100, 14'b10001000000100,
      14'b01000000000100, 14'b00001000000100, 14'b00010000000100, 14'b00100000000100,
      14'b01001000100010, 14'b10000100100010, 14'b10010000100010, 14'b10001000100010,
      14'b01000100100010, 14'b00000000100010, 14'b01000000100100, 14'b00100100100010,
      14'b01001001000010, 14'b10000001000010, 14'b10010001000010, 14'b10001001000010,
      14'b01000001000010, 14'b00000001000010, 14'b00010001000010, 14'b00100001000010,
      14'b10000000100010, 14'b10000010000010, 14'b10010010000010, 14'b00100000100010,
      14'b01000010000010, 14'b00000010000010, 14'b00010010000010, 14'b00100010000010,
      14'b01001000000010, 14'b00001001001000, 14'b10010000000010, 14'b10001000000010,
      14'b01000000000010, 14'b00001000000010, 14'b00010000000010, 14'b00100000000010,
      14'b01001000100001, 14'b10000100100001, 14'b10010000100001, 14'b10001000100001,
      14'b01000100100001, 14'b00000000100001, 14'b00010000100001, 14'b00100100100001,
      14'b01001001000001, 14'b10000001000001, 14'b10010001000001, 14'b10001001000001,
      14'b01000001000001, 14'b00000001000001, 14'b00010001000001, 14'b00100001000001,
      14'b10000000100001, 14'b10000010000001, 14'b10010010000001, 14'b00100000100001,
      14'b01000010000001, 14'b00000010000001, 14'b00010010000001, 14'b00100010000001,
      14'b01001000000001, 14'b10000010010000, 14'b10010000000001, 14'b10001000000001,
      14'b01000010010000, 14'b00001000000001, 14'b00010000000001, 14'b00100010010000,
      14'b00001000100001, 14'b10000100001001, 14'b01000100010000, 14'b00000100100001,
      14'b01000100001001, 14'b00000100001001, 14'b01000000100001, 14'b00100100001001,
      14'b01001001001001, 14'b10000001001001, 14'b10010001001001, 14'b10001001001001,
      14'b01000001001001, 14'b00000001001001, 14'b00010001001001, 14'b00100001001001,
      14'b00000100100000, 14'b10000010001001, 14'b10010010001001, 14'b00100100010000,
      14'b01000010001001, 14'b00000010001001, 14'b00010010001001, 14'b00100010001001,
      14'b01001000001001, 14'b10000000001001, 14'b10010000001001, 14'b10001000001001,
      14'b01000000001001, 14'b00001000001001, 14'b00010000001001, 14'b00100000001001,
      14'b01000100100000, 14'b10000100010001, 14'b10010010010000, 14'b00001000100100,
      14'b01000100010001, 14'b00000100010001, 14'b00010010010000, 14'b00100100010001,
      14'b00001001000001, 14'b10000100000001, 14'b00001001000100, 14'b00001001000000,
      14'b01000100000001, 14'b00000100000001, 14'b00000010010000, 14'b00100100000001,
      14'b00000100100100, 14'b10000010010001, 14'b10010010010001, 14'b10000100100000,
      14'b01000010010001, 14'b00000010010001, 14'b00010010010001, 14'b00100010010001,
      14'b01001000010001, 14'b10000000010001, 14'b10010000010001, 14'b10001000010001,
      14'b01000000010001, 14'b00001000010001, 14'b00010000010001, 14'b00100000010001,
      14'b01000100000010, 14'b00000100000010, 14'b10000100010010, 14'b00100100000010,
      14'b01000100010010, 14'b00000100010010, 14'b01000000100010, 14'b00100100010010,
      14'b10000100000010, 14'b10000100000100, 14'b00001001001001, 14'b00001001000010,
      14'b01000100000100, 14'b00000100000100, 14'b00010000100010, 14'b00100100000100,
      14'b00000100100010, 14'b10000010010010, 14'b10010010010010, 14'b00001000100010,
      14'b01000010010010, 14'b00000010010010, 14'b00010010010010, 14'b00100010010010,
      14'b01001000010010, 14'b10000000010010, 14'b10010000010010, 14'b10001000010010,
      14'b01000000010010, 14'b00001000010010, 14'b00010000010010, 14'b00100000010010
   };

   // reverse lookup: parallel match against all table entries
   function automatic dec_type efm_decode(logic [13:0] code);
      dec_type d;
      d = '0;
      if (code == SYNC0_CODE) begin
         d.sync0 = 1'b1;
      end else if (code == SYNC1_CODE) begin
         d.sync1 = 1'b1;
      end else begin
         for (int i = 0; i < 256; i++) begin
            if (EFM_CODE[i] == code) begin
               d.hit   = 1'b1;
               d.value = 8'(i);
            end
         end
      end
      return d;
   endfunction

endpackage

// ===== rtl/core/efmdec_ifs.sv =====
// handshake channel interfaces for run lengths and decoded symbols
interface efmdec_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] run_length;
   logic       frame_end;
   modport source (output valid, output run_length, output frame_end, input ready);
   modport sink (input valid, input run_length, input frame_end, output ready);
endinterface

interface efmdec_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] item_kind;
   logic [4:0] symbol_index;
   logic [7:0] symbol_value;
   logic       symbol_error;
   logic [1:0] length_class;
   logic       frame_last;
   modport source (output valid, output item_kind, output symbol_index, output symbol_value,
                   output symbol_error, output length_class, output frame_last, input ready);
   modport sink (input valid, input item_kind, input symbol_index, input symbol_value,
                 input symbol_error, input length_class, input frame_last, output ready);
endinterface

// ===== rtl/core/efm_channel_frame_decoder.sv =====
// cd channel frame eight-to-fourteen demodulator, streaming top level
//
// req carries one run length (T 3..11, clamped) per transaction, frame_end
// flags the last run of a channel frame. rsp gives decoded items: the subcode
// (or sync0/sync1 frame type), then data symbols 0..31, one per transaction.
// a run that completes a symbol gives its result via the input register and
// then the result register; runs are taken one per cycle while the result
// register can move, so throughput is one run per cycle mid-frame. data
// symbol 31 is held back until frame end so that the last item carries the
// length class. at frame end the remaining symbols of the frame come out one
// per cycle while the result register can move, from a drain sequencer (the
// subcode and all data symbols for a frame cut very short); no run is decoded
// during the drain. the frame end transaction is the one flagged frame_last,
// with length class good, short or long. when rsp stalls, the result register
// holds and the input register fills, then req.ready drops. synchronous reset
// clears the bit window, bit count, symbol progress, held flag and valid flags.
module efm_channel_frame_decoder #(
   parameter int NominalFrameBits = efmdec_pkg::NOMINAL_FRAME_BITS,
   parameter int DataSymbols      = efmdec_pkg::DATA_SYMBOLS
) (
   input  logic clock,
   input  logic reset,
   efmdec_req_if.sink   req,
   efmdec_rsp_if.source rsp
);

   localparam int WB = efmdec_pkg::WINDOW_BITS;
   localparam int PB = efmdec_pkg::POS_BITS;
   localparam int SB = efmdec_pkg::SYMBOL_BITS;
   localparam logic [PB-1:0] SUB_END = PB'(efmdec_pkg::SUBCODE_START + SB);
   localparam logic [PB-1:0] DATA_END0 = PB'(efmdec_pkg::DATA_START + SB);
   localparam logic [PB-1:0] MAX_OFF = PB'(efmdec_pkg::MAX_OFFSET);
   localparam logic [PB-1:0] NOMINAL = PB'(NominalFrameBits);
   localparam logic [5:0] LAST_SYM = 6'(DataSymbols - 1);
   localparam logic [5:0] NUM_SYM = 6'(DataSymbols);

   // input register
   logic       in_v_ff, in_v_in;
   logic [3:0] in_t_ff, in_t_in;
   logic       in_fe_ff, in_fe_in;

   // frame state
   logic [WB-1:0] win_ff, win_in;
   logic [9:0]    count_ff, count_in;
   logic          sub_done_ff, sub_done_in;
   logic [5:0]    emitted_ff, emitted_in;
   logic          held_v_ff, held_v_in;
   logic [7:0]    held_val_ff, held_val_in;
   logic          held_err_ff, held_err_in;
   logic          drain_ff, drain_in;
   logic [PB-1:0] plen_ff, plen_in;
   logic [1:0]    cls_ff, cls_in;

   // result register
   logic       out_v_ff, out_v_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic [4:0] out_idx_ff, out_idx_in;
   logic [7:0] out_val_ff, out_val_in;
   logic       out_err_ff, out_err_in;
   logic [1:0] out_cls_ff, out_cls_in;
   logic       out_last_ff, out_last_in;

   logic          out_free, consume;
   logic [3:0]    t_clamp;
   logic [WB-1:0] win_new, win_pad;
   logic [PB-1:0] nw, plen, end_pos, off_n, off_d;
   logic [2:0]    pad;
   logic          pending, final_pend, emit_n, emit_d;
   logic [WB-1:0] code_src;
   logic [3:0]    code_off;
   logic [13:0]   code_sel;
   logic          padded;
   efmdec_pkg::dec_type dec;
   logic [1:0]    it_kind;
   logic [7:0]    it_val;
   logic          it_err;
   logic [1:0]    cls_now;

   assign out_free = !out_v_ff || rsp.ready;
   assign consume  = in_v_ff && !drain_ff && out_free;
   assign req.ready = !in_v_ff || consume;

   // new window and bit position for the run in the input register
   always_comb begin
      if (in_t_ff < 4'(efmdec_pkg::T_MIN)) begin
         t_clamp = 4'(efmdec_pkg::T_MIN);
      end else if (in_t_ff > 4'(efmdec_pkg::T_MAX)) begin
         t_clamp = 4'(efmdec_pkg::T_MAX);
      end else begin
         t_clamp = in_t_ff;
      end
      win_new = (win_ff << t_clamp) | (WB'(1) << (t_clamp - 4'd1));
      nw      = PB'(count_ff) + PB'(t_clamp);
      pad     = 3'd0 - nw[2:0];
      plen    = nw + PB'(pad);
      win_pad = win_new << pad;
      if (nw < NOMINAL) begin
         cls_now = efmdec_pkg::LEN_SHORT;
      end else if (nw == NOMINAL) begin
         cls_now = efmdec_pkg::LEN_GOOD;
      end else begin
         cls_now = efmdec_pkg::LEN_LONG;
      end
   end

   // end position of the next pending symbol: 17k as 16k + k
   always_comb begin
      pending    = !sub_done_ff || (emitted_ff < NUM_SYM);
      final_pend = sub_done_ff && (emitted_ff == LAST_SYM);
      if (!sub_done_ff) begin
         end_pos = SUB_END;
      end else begin
         end_pos = DATA_END0 + (PB'(emitted_ff) << 4) + PB'(emitted_ff);
      end
      off_n  = nw - end_pos;
      off_d  = plen_ff - end_pos;
      emit_n = pending && (nw >= end_pos) && (off_n < MAX_OFF);
      emit_d = (end_pos <= plen_ff) && (off_d < MAX_OFF);
   end

   // one shared decoder for the run path and the drain path
   always_comb begin
      code_src = drain_ff ? win_ff : win_new;
      code_off = drain_ff ? off_d[3:0] : off_n[3:0];
      code_sel = 14'(code_src >> code_off);
      padded   = drain_ff && !emit_d;
      dec      = efmdec_pkg::efm_decode(code_sel);
      if (padded) begin
         dec = '0;
      end
      it_val = dec.hit ? dec.value : 8'd0;
      it_err = !dec.hit;
      if (!sub_done_ff) begin
         if (dec.sync0) begin
            it_kind = efmdec_pkg::KIND_SYNC0;
            it_err  = 1'b0;
         end else if (dec.sync1) begin
            it_kind = efmdec_pkg::KIND_SYNC1;
            it_err  = 1'b0;
         end else begin
            it_kind = efmdec_pkg::KIND_SUBCODE;
         end
      end else begin
         it_kind = efmdec_pkg::KIND_DATA;
      end
   end

   always_comb begin
      in_v_in     = in_v_ff;
      in_t_in     = in_t_ff;
      in_fe_in    = in_fe_ff;
      win_in      = win_ff;
      count_in    = count_ff;
      sub_done_in = sub_done_ff;
      emitted_in  = emitted_ff;
      held_v_in   = held_v_ff;
      held_val_in = held_val_ff;
      held_err_in = held_err_ff;
      drain_in    = drain_ff;
      plen_in     = plen_ff;
      cls_in      = cls_ff;
      out_v_in    = out_v_ff && !rsp.ready;
      out_kind_in = out_kind_ff;
      out_idx_in  = out_idx_ff;
      out_val_in  = out_val_ff;
      out_err_in  = out_err_ff;
      out_cls_in  = out_cls_ff;
      out_last_in = out_last_ff;

      if (consume) begin
         in_v_in = 1'b0;
      end
      if (req.valid && req.ready) begin
         in_v_in  = 1'b1;
         in_t_in  = req.run_length;
         in_fe_in = req.frame_end;
      end

      if (consume) begin
         // run path: at most one symbol completes per run
         win_in   = win_new;
         count_in = (nw > PB'(10'h3FF)) ? 10'h3FF : nw[9:0];
         if (emit_n) begin
            if (!sub_done_ff) begin
               sub_done_in = 1'b1;
            end else begin
               emitted_in = emitted_ff + 6'd1;
            end
            if (!in_fe_ff && final_pend) begin
               held_v_in   = 1'b1;
               held_val_in = it_val;
               held_err_in = it_err;
            end else begin
               out_v_in    = 1'b1;
               out_kind_in = it_kind;
               out_idx_in  = sub_done_ff ? emitted_ff[4:0] : 5'd0;
               out_val_in  = it_val;
               out_err_in  = it_err;
               out_last_in = in_fe_ff && final_pend && !held_v_ff;
               out_cls_in  = (in_fe_ff && final_pend && !held_v_ff) ? cls_now
                                                                    : efmdec_pkg::LEN_GOOD;
            end
         end
         if (in_fe_ff) begin
            if (emit_n && final_pend && !held_v_ff) begin
               // frame closed by this run: back to start of frame
               win_in      = '0;
               count_in    = '0;
               sub_done_in = 1'b0;
               emitted_in  = '0;
            end else begin
               drain_in = 1'b1;
               win_in   = win_pad;
               plen_in  = plen;
               cls_in   = cls_now;
            end
         end
      end else if (drain_ff && out_free) begin
         if (pending) begin
            if (!sub_done_ff) begin
               sub_done_in = 1'b1;
            end else begin
               emitted_in = emitted_ff + 6'd1;
            end
            out_v_in    = 1'b1;
            out_kind_in = it_kind;
            out_idx_in  = sub_done_ff ? emitted_ff[4:0] : 5'd0;
            out_val_in  = it_val;
            out_err_in  = it_err;
            out_last_in = final_pend && !held_v_ff;
            out_cls_in  = (final_pend && !held_v_ff) ? cls_ff : efmdec_pkg::LEN_GOOD;
         end else if (held_v_ff) begin
            out_v_in    = 1'b1;
            out_kind_in = efmdec_pkg::KIND_DATA;
            out_idx_in  = LAST_SYM[4:0];
            out_val_in  = held_val_ff;
            out_err_in  = held_err_ff;
            out_last_in = 1'b1;
            out_cls_in  = cls_ff;
         end
         // frame finished: clear for the next one
         if ((pending && final_pend && !held_v_ff) || !pending) begin
            drain_in    = 1'b0;
            win_in      = '0;
            count_in    = '0;
            sub_done_in = 1'b0;
            emitted_in  = '0;
            held_v_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff     <= 1'b0;
         win_ff      <= '0;
         count_ff    <= '0;
         sub_done_ff <= 1'b0;
         emitted_ff  <= '0;
         held_v_ff   <= 1'b0;
         drain_ff    <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         in_v_ff     <= in_v_in;
         win_ff      <= win_in;
         count_ff    <= count_in;
         sub_done_ff <= sub_done_in;
         emitted_ff  <= emitted_in;
         held_v_ff   <= held_v_in;
         drain_ff    <= drain_in;
         out_v_ff    <= out_v_in;
      end
      in_t_ff     <= in_t_in;
      in_fe_ff    <= in_fe_in;
      held_val_ff <= held_val_in;
      held_err_ff <= held_err_in;
      plen_ff     <= plen_in;
      cls_ff      <= cls_in;
      out_kind_ff <= out_kind_in;
      out_idx_ff  <= out_idx_in;
      out_val_ff  <= out_val_in;
      out_err_ff  <= out_err_in;
      out_cls_ff  <= out_cls_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.item_kind    = out_kind_ff;
   assign rsp.symbol_index = out_idx_ff;
   assign rsp.symbol_value = out_val_ff;
   assign rsp.symbol_error = out_err_ff;
   assign rsp.length_class = out_cls_ff;
   assign rsp.frame_last   = out_last_ff;

endmodule
